// ===== design/ks01tb_pkg.sv =====
// Shared types, sizes, register codes and the controller state type of the
// 0/1 knapsack solver. No dependencies; used by every other design file.
`timescale 1ns / 1ps
`default_nettype none

package ks01tb_pkg;

	localparam int MAX_ITEMS    = 32;
	localparam int MAX_CAPACITY = 255;
	localparam int VALUE_BITS   = 16;

	localparam int COLS        = MAX_CAPACITY + 1;
	localparam int COL_BITS    = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int IDX_BITS    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_BITS    = $clog2(MAX_ITEMS + 1);
	localparam int STORE_VBITS = (VALUE_BITS < 16) ? VALUE_BITS : 16;
	localparam int TOTAL_BITS  = 21;
	localparam int SUM_BITS    = TOTAL_BITS + 1;
	localparam int SZW_BITS    = COL_BITS + 8;

	typedef logic [COL_BITS-1:0]    col_t;
	typedef logic [IDX_BITS-1:0]    idx_t;
	typedef logic [CNT_BITS-1:0]    cnt_t;
	typedef logic [STORE_VBITS-1:0] sval_t;
	typedef logic [TOTAL_BITS-1:0]  total_t;
	typedef logic [SUM_BITS-1:0]    sum_t;
	typedef logic [SZW_BITS-1:0]    szw_t;
	typedef logic [5:0]             fld6_t;
	typedef logic [15:0]            fld16_t;

	localparam total_t TOTAL_MAX = '1;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_TB_INIT,
		ST_TB1_RD,
		ST_TB1_EV,
		ST_SUM,
		ST_TB2_RD,
		ST_TB2_EV,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic accept;
		logic sweep_issue;
		logic item_done;
		logic tb_init;
		logic tb_rewind;
		logic tb_read;
		logic tb_step;
		logic tb_count;
		logic load_sum;
		logic emit_item;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic col_zero;
		logic i_zero;
		logic take;
		logic cnt_zero;
		logic out_free;
	} sts_t;

	function automatic col_t sat_cap(input logic [7:0] c);
		if (32'(c) > MAX_CAPACITY)
			return col_t'(MAX_CAPACITY);
		return col_t'(c);
	endfunction

endpackage

`default_nettype wire

// ===== design/ks01tb_ctrl.sv =====
// Sequencing state machine: column sweep per item, two traceback passes
// (count, then emit) and the clear step. Depends on ks01tb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ks01tb_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_last,
	output logic                in_ready,
	input  ks01tb_pkg::sts_t    sts,
	output ks01tb_pkg::cmd_t    cmd
);

	ks01tb_pkg::state_t state_q, state_d;
	logic last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ks01tb_pkg::ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept)
				last_q <= in_last;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ks01tb_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!sts.full)
						state_d = ks01tb_pkg::ST_SWEEP;
					else if (in_last)
						state_d = ks01tb_pkg::ST_TB_INIT;
				end
			end
			ks01tb_pkg::ST_SWEEP: begin
				if (sts.col_zero)
					state_d = ks01tb_pkg::ST_DRAIN;
			end
			ks01tb_pkg::ST_DRAIN: begin
				state_d = last_q ? ks01tb_pkg::ST_TB_INIT : ks01tb_pkg::ST_IDLE;
			end
			ks01tb_pkg::ST_TB_INIT: state_d = ks01tb_pkg::ST_TB1_RD;
			ks01tb_pkg::ST_TB1_RD: begin
				state_d = sts.i_zero ? ks01tb_pkg::ST_SUM : ks01tb_pkg::ST_TB1_EV;
			end
			ks01tb_pkg::ST_TB1_EV: state_d = ks01tb_pkg::ST_TB1_RD;
			ks01tb_pkg::ST_SUM: begin
				if (sts.out_free)
					state_d = sts.cnt_zero ? ks01tb_pkg::ST_CLEAR : ks01tb_pkg::ST_TB2_RD;
			end
			ks01tb_pkg::ST_TB2_RD: begin
				state_d = sts.i_zero ? ks01tb_pkg::ST_CLEAR : ks01tb_pkg::ST_TB2_EV;
			end
			ks01tb_pkg::ST_TB2_EV: begin
				if (!sts.take || sts.out_free)
					state_d = ks01tb_pkg::ST_TB2_RD;
			end
			ks01tb_pkg::ST_CLEAR: state_d = ks01tb_pkg::ST_IDLE;
			default: state_d = ks01tb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ks01tb_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ks01tb_pkg::ST_SWEEP:   cmd.sweep_issue = 1'b1;
			ks01tb_pkg::ST_DRAIN:   cmd.item_done = 1'b1;
			ks01tb_pkg::ST_TB_INIT: cmd.tb_init = 1'b1;
			ks01tb_pkg::ST_TB1_RD:  cmd.tb_read = !sts.i_zero;
			ks01tb_pkg::ST_TB1_EV: begin
				cmd.tb_step  = 1'b1;
				cmd.tb_count = 1'b1;
			end
			ks01tb_pkg::ST_SUM: begin
				cmd.load_sum  = sts.out_free;
				cmd.tb_rewind = sts.out_free;
			end
			ks01tb_pkg::ST_TB2_RD:  cmd.tb_read = !sts.i_zero;
			ks01tb_pkg::ST_TB2_EV: begin
				// hold the read data until the output register can take the record
				cmd.tb_step   = !sts.take || sts.out_free;
				cmd.emit_item = sts.take && sts.out_free;
			end
			ks01tb_pkg::ST_CLEAR:   cmd.clear = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/ks01tb_dp.sv =====
// Datapath: best-total row with valid bits, take-bit store, item store,
// traceback counters and the result register. Depends on ks01tb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ks01tb_dp (
	input  wire                    clk,
	input  wire                    arst_n,
	input  ks01tb_pkg::cmd_t       cmd,
	output ks01tb_pkg::sts_t       sts,
	input  wire  [15:0]            in_value,
	input  wire  [7:0]             in_size,
	input  ks01tb_pkg::col_t       cap,
	input  wire                    m_tready,
	output logic                   m_tvalid,
	output logic [63:0]            m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	// item being swept
	ks01tb_pkg::sval_t val_q;
	logic [7:0]        size_q;
	ks01tb_pkg::cnt_t  items_q;
	ks01tb_pkg::col_t  col_q;
	ks01tb_pkg::idx_t  widx;
	logic              full;

	// stores
	ks01tb_pkg::total_t best_mem [0:ks01tb_pkg::COLS-1];
	logic [ks01tb_pkg::COLS-1:0] best_vld_q;
	logic take_mem [0:ks01tb_pkg::MAX_ITEMS-1][0:ks01tb_pkg::COLS-1];
	ks01tb_pkg::sval_t vals_mem  [0:ks01tb_pkg::MAX_ITEMS-1];
	logic [7:0]        sizes_mem [0:ks01tb_pkg::MAX_ITEMS-1];

	// sweep pipeline
	ks01tb_pkg::col_t   addr_hi, addr_lo, col_s1;
	ks01tb_pkg::szw_t   lo_diff;
	logic               rd_en_hi, ok, en_s1, ok_s1, hv_s1, lv_s1, better;
	ks01tb_pkg::total_t rd_hi_s1, rd_lo_s1, hi_val, lo_val, cand;
	ks01tb_pkg::sum_t   sum;

	// traceback
	ks01tb_pkg::cnt_t  tb_i_q, cnt_q, emit_q;
	ks01tb_pkg::col_t  tb_j_q;
	ks01tb_pkg::idx_t  ridx;
	logic              take_rd_s1;
	logic [7:0]        sz_rd_s1;
	ks01tb_pkg::sval_t vl_rd_s1;

	// result register
	logic               out_free, kind_q, fin_q;
	ks01tb_pkg::total_t tot_q;
	ks01tb_pkg::fld6_t  ocnt_q, onum_q;
	ks01tb_pkg::fld16_t oval_q;
	logic [7:0]         osize_q;

	assign full = (items_q == ks01tb_pkg::cnt_t'(ks01tb_pkg::MAX_ITEMS));
	assign widx = ks01tb_pkg::idx_t'(items_q);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q  <= in_value[ks01tb_pkg::STORE_VBITS-1:0];
			size_q <= in_size;
		end
		if (cmd.accept && !full) begin
			vals_mem[widx]  <= in_value[ks01tb_pkg::STORE_VBITS-1:0];
			sizes_mem[widx] <= in_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q <= '0;
			col_q   <= '0;
		end else begin
			if (cmd.clear)
				items_q <= '0;
			else if (cmd.item_done)
				items_q <= items_q + ks01tb_pkg::cnt_t'(1);
			if (cmd.accept)
				col_q <= ks01tb_pkg::col_t'(ks01tb_pkg::MAX_CAPACITY);
			else if (cmd.sweep_issue)
				col_q <= col_q - ks01tb_pkg::col_t'(1);
		end
	end

	// Columns go downwards, so column j-size is read before any write to it
	// lands; the write of j+1 and the reads of j, j-size never collide.
	assign lo_diff  = ks01tb_pkg::szw_t'(col_q) - ks01tb_pkg::szw_t'(size_q);
	assign addr_lo  = ks01tb_pkg::col_t'(lo_diff);
	assign addr_hi  = cmd.tb_init ? cap : col_q;
	assign rd_en_hi = cmd.sweep_issue || cmd.tb_init;
	assign ok       = (ks01tb_pkg::szw_t'(col_q) >= ks01tb_pkg::szw_t'(size_q)) &&
	                  (col_q != '0);

	always_ff @(posedge clk) begin
		if (rd_en_hi) begin
			rd_hi_s1 <= best_mem[addr_hi];
			hv_s1    <= best_vld_q[addr_hi];
		end
		if (cmd.sweep_issue) begin
			rd_lo_s1 <= best_mem[addr_lo];
			lv_s1    <= best_vld_q[addr_lo];
			col_s1   <= col_q;
			ok_s1    <= ok;
		end
		if (better)
			best_mem[col_s1] <= cand;
		if (en_s1)
			take_mem[widx][col_s1] <= better;
	end

	assign hi_val = hv_s1 ? rd_hi_s1 : '0;
	assign lo_val = lv_s1 ? rd_lo_s1 : '0;
	assign sum    = ks01tb_pkg::sum_t'(lo_val) + ks01tb_pkg::sum_t'(val_q);
	assign cand   = sum[ks01tb_pkg::TOTAL_BITS] ? ks01tb_pkg::TOTAL_MAX
	                : sum[ks01tb_pkg::TOTAL_BITS-1:0];
	assign better = en_s1 && ok_s1 && (cand > hi_val);

	// a cleared entry reads as zero until written again
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= '0;
			en_s1      <= 1'b0;
		end else begin
			en_s1 <= cmd.sweep_issue;
			if (cmd.clear)
				best_vld_q <= '0;
			else if (better)
				best_vld_q[col_s1] <= 1'b1;
		end
	end

	// traceback walks items downwards; pass one counts, pass two emits
	assign ridx = ks01tb_pkg::idx_t'(tb_i_q - ks01tb_pkg::cnt_t'(1));

	always_ff @(posedge clk) begin
		if (cmd.tb_read) begin
			take_rd_s1 <= take_mem[ridx][tb_j_q];
			sz_rd_s1   <= sizes_mem[ridx];
			vl_rd_s1   <= vals_mem[ridx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tb_i_q <= '0;
			tb_j_q <= '0;
			cnt_q  <= '0;
			emit_q <= '0;
		end else begin
			if (cmd.tb_init || cmd.tb_rewind) begin
				tb_i_q <= items_q;
				tb_j_q <= cap;
			end else if (cmd.tb_step) begin
				tb_i_q <= tb_i_q - ks01tb_pkg::cnt_t'(1);
				if (take_rd_s1)
					tb_j_q <= ks01tb_pkg::col_t'(ks01tb_pkg::szw_t'(tb_j_q) -
					                             ks01tb_pkg::szw_t'(sz_rd_s1));
			end
			if (cmd.tb_init)
				cnt_q <= '0;
			else if (cmd.tb_step && cmd.tb_count && take_rd_s1)
				cnt_q <= cnt_q + ks01tb_pkg::cnt_t'(1);
			if (cmd.tb_rewind)
				emit_q <= '0;
			else if (cmd.emit_item)
				emit_q <= emit_q + ks01tb_pkg::cnt_t'(1);
		end
	end

	// result register; the summary total is the hi-port word read at tb_init,
	// which stays put because nothing reads that port again until the next set
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (cmd.load_sum || cmd.emit_item)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sum) begin
			kind_q  <= 1'b0;
			tot_q   <= hi_val;
			ocnt_q  <= ks01tb_pkg::fld6_t'(cnt_q);
			onum_q  <= '0;
			oval_q  <= '0;
			osize_q <= '0;
			fin_q   <= (cnt_q == '0);
		end else if (cmd.emit_item) begin
			kind_q  <= 1'b1;
			tot_q   <= '0;
			ocnt_q  <= '0;
			onum_q  <= ks01tb_pkg::fld6_t'(tb_i_q);
			oval_q  <= ks01tb_pkg::fld16_t'(vl_rd_s1);
			osize_q <= sz_rd_s1;
			fin_q   <= ((emit_q + ks01tb_pkg::cnt_t'(1)) == cnt_q);
		end
	end

	assign m_tdata = {7'b0, osize_q, oval_q, onum_q, ocnt_q, tot_q};
	assign m_tuser = kind_q;
	assign m_tlast = fin_q;

	assign sts.full     = full;
	assign sts.col_zero = (col_q == '0);
	assign sts.i_zero   = (tb_i_q == '0);
	assign sts.take     = take_rd_s1;
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.out_free = out_free;

	a_items_bound: assert property (@(posedge clk) disable iff (!arst_n)
		items_q <= ks01tb_pkg::cnt_t'(ks01tb_pkg::MAX_ITEMS))
		else $error("item count beyond store depth");

	a_tb_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tb_step && take_rd_s1) |->
		(ks01tb_pkg::szw_t'(tb_j_q) >= ks01tb_pkg::szw_t'(sz_rd_s1)))
		else $error("traceback column would wrap below zero");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_item |-> (emit_q < cnt_q))
		else $error("more item records than counted");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(cmd.load_sum || cmd.emit_item))
		else $error("result register loaded while a transfer is pending");

endmodule

`default_nettype wire

// ===== design/knapsack_01_with_traceback_unit.sv =====
// Top level of the 0/1 knapsack solver: APB capacity register, controller
// and datapath. Depends on ks01tb_pkg, ks01tb_ctrl and ks01tb_dp.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    tdata: item_value[15:0], item_size[23:16]
//                                       tlast: last_item
//  m_*      out  m_tvalid / m_tready    tdata: best_total, chosen_count,
//                                       item_number, chosen_value, chosen_size
//                                       tuser: kind   tlast: final_record
//  apb      in   psel/penable/pready    capacity at byte address 0
//
// Each item is accepted, then swept with one read per capacity column on the
// two-read-port best-total row, then drained. After the last item the
// traceback makes two passes over the stored items through the take-bit
// store, one to count and one to emit; with nothing chosen the second pass
// is skipped. Results stall on m_tready without losing state; inputs are
// taken only between items.
// Reset leaves the row reading as zero at once via per-column valid bits.
`timescale 1ns / 1ps
`default_nettype none

module knapsack_01_with_traceback_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // item_value[15:0], item_size[23:16]
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,   // best_total[20:0], chosen_count[26:21],
	                               // item_number[32:27], chosen_value[48:33],
	                               // chosen_size[56:49], zero[63:57]
	output logic        m_tuser,   // kind
	output logic        m_tlast,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]       cap_q;
	logic             reg_idx;
	ks01tb_pkg::cmd_t cmd;
	ks01tb_pkg::sts_t sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cap_q <= '0;
		else if (psel && penable && pwrite && pready &&
		         reg_idx == ks01tb_pkg::REG_CAPACITY)
			cap_q <= pwdata[7:0];
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			ks01tb_pkg::REG_CAPACITY: prdata = {24'b0, cap_q};
			default: prdata = '0;
		endcase
	end

	ks01tb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ks01tb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_value (s_tdata[15:0]),
		.in_size  (s_tdata[23:16]),
		.cap      (ks01tb_pkg::sat_cap(cap_q)),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
